// ===== design/running_time_weighted_stats_core_assert.svh =====
// Assertion macros for the running time-weighted statistics core.
`ifndef RUNNING_TIME_WEIGHTED_STATS_CORE_ASSERT_SVH
`define RUNNING_TIME_WEIGHTED_STATS_CORE_ASSERT_SVH

// Checked outside reset.
`define RTWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
  else $error(msg);

// Checked at every edge, reset included.
`define RTWS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
  else $error(msg);

`endif

// ===== design/rtws_pkg.sv =====
// Shared types, constants and saturating adders for the statistics core.
package rtws_pkg;

  localparam int unsigned QDepthDef = 2;
  localparam logic [62:0] Max63 = {63{1'b1}};

  typedef struct packed {
    logic signed [31:0] sample;
    logic [31:0]        timestamp;
    logic [15:0]        weight;
    logic [46:0]        square;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SW, ST_SQW, ST_ACC, ST_TRAP, ST_HOLD, ST_PSQ, ST_HLO,
    ST_HHI, ST_AREA, ST_DSET, ST_DIVS, ST_DIVQ, ST_MM, ST_OUT
  } state_e;

  function automatic logic signed [63:0] sat_add_s(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic [62:0] sat_add_u63(input logic [62:0] a, input logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[63] ? Max63 : s[62:0];
  endfunction

endpackage

// ===== design/running_time_weighted_stats_core.sv =====
// Top level of the running time-weighted statistics core.
// Input channel: in_valid_i/in_ready_o with sample_i (signed Q16.16),
// timestamp_i (ticks) and weight_i. Output channel: out_valid_o/out_ready_i
// with one result per input transaction: count, sum, mean, variance,
// min, max, trapezoid, held and held-square areas, and elapsed time.
// A front stage registers each transaction and squares the sample; a
// queue decouples it from the back engine, which works one item at a time.
// Back engine: an item whose count stays zero goes from accumulation straight
// to the output state; otherwise two 64-step serial divisions (sum and sum
// of squares over count) follow, after the area update steps if time advances.
// Reset clears all statistics, min to the most positive and max to the
// most negative value, and leaves no result pending.
// A stalled receiver holds the result register; the engine then waits
// before loading the next result, and the queue and front stage keep
// taking transactions until they are full.
module running_time_weighted_stats_core #(
  parameter int unsigned QueueDepth = rtws_pkg::QDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] sample_i,
  input  logic [31:0]        timestamp_i,
  input  logic [15:0]        weight_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        total_count_o,
  output logic signed [63:0] total_sum_o,
  output logic signed [31:0] mean_value_o,
  output logic [62:0]        variance_value_o,
  output logic signed [31:0] min_value_o,
  output logic signed [31:0] max_value_o,
  output logic signed [63:0] trapezoid_area_o,
  output logic signed [63:0] held_area_o,
  output logic [62:0]        held_square_area_o,
  output logic [62:0]        elapsed_total_o
);
  import rtws_pkg::*;

  item_t f_data, q_data;
  logic  f_valid, f_ready, q_valid, q_ready;

  rtws_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .sample_i, .timestamp_i, .weight_i,
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_data_o  (f_data)
  );

  rtws_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (f_data),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_data)
  );

  rtws_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i (q_valid),
    .in_ready_o (q_ready),
    .in_data_i  (q_data),
    .out_valid_o, .out_ready_i, .total_count_o, .total_sum_o, .mean_value_o,
    .variance_value_o, .min_value_o, .max_value_o, .trapezoid_area_o,
    .held_area_o, .held_square_area_o, .elapsed_total_o
  );

endmodule

// ===== design/rtws_queue.sv =====
// Short transaction queue between the front and back parts.
module rtws_queue #(
  parameter int unsigned Depth = rtws_pkg::QDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rtws_pkg::item_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rtws_pkg::item_t out_data_o
);
  import rtws_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              push, pop;

  assign in_ready_o  = (cnt_q != CntW'(Depth));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

endmodule

// ===== design/rtws_front.sv =====
// Input stage: takes transactions and precomputes the square of the Q16.16 sample (unsigned Q31.16).
module rtws_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] sample_i,
  input  logic [31:0]        timestamp_i,
  input  logic [15:0]        weight_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rtws_pkg::item_t    out_data_o
);
  import rtws_pkg::*;

  logic               f_v_q;
  item_t              f_q;
  logic               acc;
  logic signed [63:0] prod;

  assign in_ready_o  = !f_v_q || out_ready_i;
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = f_v_q;
  assign out_data_o  = f_q;
  assign prod        = sample_i * sample_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (acc) begin
      f_v_q <= 1'b1;
    end else if (out_ready_i) begin
      f_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      f_q.sample    <= sample_i;
      f_q.timestamp <= timestamp_i;
      f_q.weight    <= weight_i;
      f_q.square    <= prod[62:16];
    end
  end

endmodule

// ===== design/rtws_back.sv =====
// Execution engine: accumulation, area updates, shared divider and result register.
module rtws_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rtws_pkg::item_t    in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        total_count_o,
  output logic signed [63:0] total_sum_o,
  output logic signed [31:0] mean_value_o,
  output logic [62:0]        variance_value_o,
  output logic signed [31:0] min_value_o,
  output logic signed [31:0] max_value_o,
  output logic signed [63:0] trapezoid_area_o,
  output logic signed [63:0] held_area_o,
  output logic [62:0]        held_square_area_o,
  output logic [62:0]        elapsed_total_o
);
  import rtws_pkg::*;

  state_e state_q, state_d;

  // architectural state
  logic [31:0]        count_q;
  logic signed [63:0] sum_q;
  logic [62:0]        sqsum_q;
  logic signed [31:0] low_q, high_q, prev_s_q;
  logic [31:0]        prev_t_q;
  logic signed [63:0] trap_q, hold_q;
  logic [62:0]        hsq_q, elap_q;
  logic               first_q;

  // working registers
  item_t              it_q;
  logic signed [48:0] sw_q;
  logic [62:0]        sqw_q;
  logic               zero_q;
  logic [31:0]        dt_q;
  logic signed [32:0] tot_q;
  logic signed [31:0] pe_q;
  logic [63:0]        trap_p_q;
  logic signed [63:0] hold_p_q;
  logic [46:0]        psq_q;
  logic [63:0]        hlo_q;
  logic [46:0]        hhi_q;
  logic [63:0]        quo_q;
  logic [31:0]        rem_q;
  logic [5:0]         dcnt_q;
  logic signed [31:0] mean_q;
  logic [62:0]        msq_q;
  logic [47:0]        mm_q;
  logic               ov_q;

  logic [32:0]        c33;
  logic [31:0]        cnt_n;
  logic signed [31:0] pe;
  logic [31:0]        pt;
  logic               adv;
  logic [32:0]        mag;
  logic signed [63:0] pp, mp;
  logic [62:0]        half;
  logic signed [63:0] trap_inc;
  logic [64:0]        hsq_p65;
  logic [62:0]        hsq_inc;
  logic [32:0]        sh, diff;
  logic               ge;
  logic [31:0]        rem_n;
  logic [63:0]        quo_n;
  logic signed [31:0] mean_n;
  logic               load;
  logic [62:0]        var_n;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ov_q;
  assign load        = !ov_q || out_ready_i;

  always_comb begin
    c33   = {1'b0, count_q} + {17'b0, it_q.weight};
    cnt_n = c33[32] ? '1 : c33[31:0];
    pe    = first_q ? it_q.sample : prev_s_q;
    pt    = first_q ? it_q.timestamp : prev_t_q;
    adv   = (cnt_n != '0) && (it_q.timestamp > pt);
    mag   = tot_q[32] ? -tot_q : tot_q;
    pp    = pe_q * pe_q;
    mp    = mean_q * mean_q;
    half  = trap_p_q[63:1];
    trap_inc = tot_q[32] ? -$signed({1'b0, half}) : $signed({1'b0, half});
    hsq_p65  = {2'b0, hhi_q[30:0], 32'b0} + {1'b0, hlo_q};
    if (hhi_q[46:31] != '0 || hsq_p65[64:63] != 2'b00) begin
      hsq_inc = Max63;
    end else begin
      hsq_inc = hsq_p65[62:0];
    end
    sh    = {rem_q, quo_q[63]};
    diff  = sh - {1'b0, count_q};
    ge    = (sh >= {1'b0, count_q});
    rem_n = ge ? diff[31:0] : sh[31:0];
    quo_n = {quo_q[62:0], ge};
    if (!sum_q[63]) begin
      mean_n = (quo_n > 64'h7fff_ffff) ? 32'sh7fff_ffff : $signed(quo_n[31:0]);
    end else begin
      mean_n = (quo_n > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(quo_n[31:0]);
    end
    if (zero_q || msq_q <= {15'b0, mm_q}) begin
      var_n = '0;
    end else begin
      var_n = msq_q - {15'b0, mm_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SW;
      ST_SW:   state_d = ST_SQW;
      ST_SQW:  state_d = ST_ACC;
      ST_ACC: begin
        if (cnt_n == '0) begin
          state_d = ST_OUT;
        end else if (adv) begin
          state_d = ST_TRAP;
        end else begin
          state_d = ST_DSET;
        end
      end
      ST_TRAP: state_d = ST_HOLD;
      ST_HOLD: state_d = ST_PSQ;
      ST_PSQ:  state_d = ST_HLO;
      ST_HLO:  state_d = ST_HHI;
      ST_HHI:  state_d = ST_AREA;
      ST_AREA: state_d = ST_DSET;
      ST_DSET: state_d = ST_DIVS;
      ST_DIVS: if (dcnt_q == '1) state_d = ST_DIVQ;
      ST_DIVQ: if (dcnt_q == '1) state_d = ST_MM;
      ST_MM:   state_d = ST_OUT;
      ST_OUT:  if (load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sum_q    <= '0;
      sqsum_q  <= '0;
      low_q    <= 32'sh7fff_ffff;
      high_q   <= 32'sh8000_0000;
      prev_s_q <= '0;
      prev_t_q <= '0;
      trap_q   <= '0;
      hold_q   <= '0;
      hsq_q    <= '0;
      elap_q   <= '0;
      first_q  <= 1'b1;
      ov_q     <= 1'b0;
    end else begin
      if (state_q == ST_ACC) begin
        count_q  <= cnt_n;
        prev_s_q <= it_q.sample;
        prev_t_q <= it_q.timestamp;
        if (cnt_n == '0) begin
          sum_q   <= {{32{it_q.sample[31]}}, it_q.sample};
          sqsum_q <= {16'b0, it_q.square};
          low_q   <= it_q.sample;
          high_q  <= it_q.sample;
          trap_q  <= '0;
          hold_q  <= '0;
          hsq_q   <= '0;
          elap_q  <= '0;
        end else begin
          sum_q   <= sat_add_s(sum_q, {{15{sw_q[48]}}, sw_q});
          sqsum_q <= sat_add_u63(sqsum_q, sqw_q);
          first_q <= 1'b0;
          if (it_q.sample < low_q) low_q <= it_q.sample;
          if (it_q.sample > high_q) high_q <= it_q.sample;
        end
      end
      if (state_q == ST_AREA) begin
        trap_q <= sat_add_s(trap_q, trap_inc);
        hold_q <= sat_add_s(hold_q, hold_p_q);
        hsq_q  <= sat_add_u63(hsq_q, hsq_inc);
        elap_q <= sat_add_u63(elap_q, {31'b0, dt_q});
      end
      if (state_q == ST_OUT && load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (in_valid_i) it_q <= in_data_i;
      ST_SW:   sw_q <= it_q.sample * $signed({1'b0, it_q.weight});
      ST_SQW:  sqw_q <= {16'b0, it_q.square} * {47'b0, it_q.weight};
      ST_ACC: begin
        zero_q <= (cnt_n == '0);
        dt_q   <= it_q.timestamp - pt;
        tot_q  <= {it_q.sample[31], it_q.sample} + {pe[31], pe};
        pe_q   <= pe;
      end
      ST_TRAP: trap_p_q <= {32'b0, dt_q} * {31'b0, mag};
      ST_HOLD: hold_p_q <= $signed({1'b0, dt_q}) * pe_q;
      ST_PSQ:  psq_q <= pp[62:16];
      ST_HLO:  hlo_q <= {32'b0, dt_q} * {32'b0, psq_q[31:0]};
      ST_HHI:  hhi_q <= {15'b0, dt_q} * {32'b0, psq_q[46:32]};
      ST_DSET: begin
        quo_q  <= sum_q[63] ? -sum_q : sum_q;
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      ST_DIVS: begin
        dcnt_q <= dcnt_q + 1'b1;
        if (dcnt_q == '1) begin
          mean_q <= mean_n;
          quo_q  <= {1'b0, sqsum_q};
          rem_q  <= '0;
        end else begin
          quo_q <= quo_n;
          rem_q <= rem_n;
        end
      end
      ST_DIVQ: begin
        dcnt_q <= dcnt_q + 1'b1;
        quo_q  <= quo_n;
        rem_q  <= rem_n;
        if (dcnt_q == '1) msq_q <= quo_n[62:0];
      end
      ST_MM: mm_q <= mp[63:16];
      ST_OUT: begin
        if (load) begin
          total_count_o      <= count_q;
          total_sum_o        <= sum_q;
          mean_value_o       <= zero_q ? it_q.sample : mean_q;
          variance_value_o   <= var_n;
          min_value_o        <= low_q;
          max_value_o        <= high_q;
          trapezoid_area_o   <= trap_q;
          held_area_o        <= hold_q;
          held_square_area_o <= hsq_q;
          elapsed_total_o    <= elap_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/rtws_checker.sv =====
// Port-level checker for the statistics core, with its bind.
`include "running_time_weighted_stats_core_assert.svh"
module rtws_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic signed [31:0] sample_i,
  input logic [31:0]        timestamp_i,
  input logic [15:0]        weight_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [31:0]        total_count_o,
  input logic signed [63:0] total_sum_o,
  input logic signed [31:0] mean_value_o,
  input logic [62:0]        variance_value_o,
  input logic signed [31:0] min_value_o,
  input logic signed [31:0] max_value_o,
  input logic signed [63:0] trapezoid_area_o,
  input logic signed [63:0] held_area_o,
  input logic [62:0]        held_square_area_o,
  input logic [62:0]        elapsed_total_o
);

  `RTWS_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid_o, "result valid in reset")
  `RTWS_ASSERT(a_result_held, out_valid_o && !out_ready_i |=> out_valid_o && $stable(total_count_o) && $stable(total_sum_o), "stalled result dropped or changed")
  `RTWS_ASSERT(a_min_le_max, out_valid_o |-> (min_value_o <= max_value_o), "min above max")
  `RTWS_ASSERT(a_zero_count, out_valid_o && (total_count_o == 32'd0) |-> (mean_value_o == min_value_o) && (max_value_o == min_value_o) && (variance_value_o == 63'd0), "zero count not primed")

endmodule

bind running_time_weighted_stats_core rtws_checker u_rtws_checker (.*);
